/* hw/rtl/tbo_pkg.sv */
// Package for the triangle/cube overlap test.
// Holds shared constants and the stage-to-stage control struct; no dependencies.
package tbo_pkg;
  localparam int HALF_BITS = 23;
  localparam logic [HALF_BITS-1:0] HALF_RESET = 23'd128;

  typedef struct packed {
    logic valid;
    logic sep;
  } stage_ctl_t;
endpackage

/* hw/rtl/tbo_mul.sv */
// Registered signed multiplier used by every product stage.
// Depends on nothing; the enable holds the product while the pipe stalls.
module tbo_mul #(
  parameter int AW = 26,
  parameter int BW = 26
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [AW-1:0]      a,
  input  logic signed [BW-1:0]      b,
  output logic signed [AW+BW-1:0]   p_r
);
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end
endmodule

/* hw/rtl/triangle_box_overlap_test.sv */
// Top level of the triangle/cube separating-axis overlap test.
// Uses tbo_pkg and tbo_mul.
//
//  channel | ports                                  | direction
//  in      | in_valid, in_stall, in_vertex*, in_center* | triangle + cube center
//  out     | out_valid, out_stall, out_overlaps     | one flag per transaction
//  cfg     | cfg_we, cfg_box_half_size              | cube half size
//
// One transaction enters per cycle while in_stall is low, through seven stages:
// difference, edges, edge products, edge tests/normal, split normal-dot products,
// partial-product merge, compare.
// An out stall while out_valid is high freezes all stages at once; nothing is lost.
// Synchronous active-low reset clears valid bits, sets half size to HALF_RESET (128).
module triangle_box_overlap_test #(
  parameter int COORD_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [tbo_pkg::HALF_BITS-1:0] cfg_box_half_size,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [COORD_BITS-1:0] in_vertex0_x,
  input  logic signed [COORD_BITS-1:0] in_vertex0_y,
  input  logic signed [COORD_BITS-1:0] in_vertex0_z,
  input  logic signed [COORD_BITS-1:0] in_vertex1_x,
  input  logic signed [COORD_BITS-1:0] in_vertex1_y,
  input  logic signed [COORD_BITS-1:0] in_vertex1_z,
  input  logic signed [COORD_BITS-1:0] in_vertex2_x,
  input  logic signed [COORD_BITS-1:0] in_vertex2_y,
  input  logic signed [COORD_BITS-1:0] in_vertex2_z,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  input  logic signed [COORD_BITS-1:0] in_center_z,
  output logic out_valid,
  input  logic out_stall,
  output logic out_overlaps
);
  import tbo_pkg::*;

  localparam int VW = COORD_BITS + 1;   // vertex relative to center
  localparam int FW = COORD_BITS + 2;   // edge
  localparam int HW = HALF_BITS + 1;    // signed half size
  localparam int PW = VW + FW;          // edge-axis product
  localparam int QW = PW + 1;           // edge-axis projection
  localparam int AW = FW + 1;           // |fu|+|fw|
  localparam int RW = HW + AW;          // edge-axis radius
  localparam int NW = 2 * FW + 1;       // normal component
  localparam int DW = NW + VW + 2;      // normal dot
  localparam int NSW = NW + 2;          // sum of |n|
  localparam int NL = NW / 2;           // low slice of a normal component
  localparam int NH = NW - NL;          // signed high slice
  localparam int SL = NSW / 2;          // low slice of sum of |n|
  localparam int SH = NSW - SL;         // high slice of sum of |n|

  logic en;
  assign en = !out_stall || !out_valid;
  assign in_stall = !en;

  logic [HALF_BITS-1:0] half_r;
  always_ff @(posedge clk) begin
    if (!rst_n) half_r <= HALF_RESET;
    else if (cfg_we) half_r <= cfg_box_half_size;
  end
  logic signed [HW-1:0] h;
  assign h = $signed({1'b0, half_r});

  function automatic logic sep3(input logic signed [DW-1:0] a, b, c, r);
    logic signed [DW-1:0] nr;
    nr = -r;
    sep3 = (a > r && b > r && c > r) || (a < nr && b < nr && c < nr);
  endfunction

  function automatic logic [DW-1:0] sx(input logic signed [DW-1:0] v);
    sx = v;
  endfunction

  stage_ctl_t c1_r, c2_r, c3_r, c4_r, c5_r, c6_r, c7_r;

  // stage 1: vertices relative to center
  logic signed [COORD_BITS-1:0] vin [3][3];
  logic signed [COORD_BITS-1:0] cin [3];
  assign vin[0][0] = in_vertex0_x; assign vin[0][1] = in_vertex0_y;
  assign vin[0][2] = in_vertex0_z; assign vin[1][0] = in_vertex1_x;
  assign vin[1][1] = in_vertex1_y; assign vin[1][2] = in_vertex1_z;
  assign vin[2][0] = in_vertex2_x; assign vin[2][1] = in_vertex2_y;
  assign vin[2][2] = in_vertex2_z;
  assign cin[0] = in_center_x; assign cin[1] = in_center_y; assign cin[2] = in_center_z;

  logic signed [VW-1:0] v1_r [3][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++)
          v1_r[i][k] <= VW'(vin[i][k]) - VW'(cin[k]);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) c1_r <= '0;
    else if (en) c1_r <= '{valid: in_valid, sep: 1'b0};
  end

  // stage 2: edges, face tests
  logic signed [VW-1:0] v2_r [3][3];
  logic signed [FW-1:0] f2_r [3][3];
  logic face_sep;
  always_comb begin
    face_sep = 1'b0;
    for (int k = 0; k < 3; k++)
      face_sep = face_sep | sep3(DW'(v1_r[0][k]), DW'(v1_r[1][k]),
                                 DW'(v1_r[2][k]), DW'(h));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      v2_r <= v1_r;
      for (int k = 0; k < 3; k++) begin
        f2_r[0][k] <= FW'(v1_r[1][k]) - FW'(v1_r[0][k]);
        f2_r[1][k] <= FW'(v1_r[2][k]) - FW'(v1_r[1][k]);
        f2_r[2][k] <= FW'(v1_r[0][k]) - FW'(v1_r[2][k]);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) c2_r <= '0;
    else if (en) c2_r <= '{valid: c1_r.valid, sep: face_sep};
  end

  // stage 3: products (registered in tbo_mul) and edge-axis radii
  logic signed [PW-1:0] pa3 [3][3][3];  // v[i][w]*f[j][u], indexed k,j,i
  logic signed [PW-1:0] pb3 [3][3][3];  // v[i][u]*f[j][w]
  logic signed [2*FW-1:0] nm3 [3][2];
  logic signed [VW-1:0] v3_r [3];
  logic signed [RW-1:0] r3 [3][3];

  for (genvar k = 0; k < 3; k++) begin : g_axis
    localparam int U = (k + 1) % 3;
    localparam int W = (k + 2) % 3;
    for (genvar j = 0; j < 3; j++) begin : g_edge
      for (genvar i = 0; i < 3; i++) begin : g_vert
        tbo_mul #(.AW(VW), .BW(FW)) u_ma (.clk(clk), .en(en),
          .a(v2_r[i][W]), .b(f2_r[j][U]), .p_r(pa3[k][j][i]));
        tbo_mul #(.AW(VW), .BW(FW)) u_mb (.clk(clk), .en(en),
          .a(v2_r[i][U]), .b(f2_r[j][W]), .p_r(pb3[k][j][i]));
      end
      tbo_mul #(.AW(HW), .BW(AW)) u_mr (.clk(clk), .en(en), .a(h),
        .b((f2_r[j][U] < 0 ? -AW'(f2_r[j][U]) : AW'(f2_r[j][U])) +
           (f2_r[j][W] < 0 ? -AW'(f2_r[j][W]) : AW'(f2_r[j][W]))),
        .p_r(r3[k][j]));
    end
    tbo_mul #(.AW(FW), .BW(FW)) u_n0 (.clk(clk), .en(en),
      .a(f2_r[0][U]), .b(f2_r[1][W]), .p_r(nm3[k][0]));
    tbo_mul #(.AW(FW), .BW(FW)) u_n1 (.clk(clk), .en(en),
      .a(f2_r[0][W]), .b(f2_r[1][U]), .p_r(nm3[k][1]));
  end
  always_ff @(posedge clk) begin
    if (en) v3_r <= v2_r[0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) c3_r <= '0;
    else if (en) c3_r <= c2_r;
  end

  // stage 4: edge-axis tests, normal
  logic edge_sep;
  logic signed [NW-1:0] n4_r [3];
  logic signed [VW-1:0] v4_r [3];
  always_comb begin
    edge_sep = 1'b0;
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++)
        edge_sep = edge_sep | sep3(
          DW'(QW'(pa3[k][j][0]) - QW'(pb3[k][j][0])),
          DW'(QW'(pa3[k][j][1]) - QW'(pb3[k][j][1])),
          DW'(QW'(pa3[k][j][2]) - QW'(pb3[k][j][2])),
          DW'(r3[k][j]));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      v4_r <= v3_r;
      for (int k = 0; k < 3; k++)
        n4_r[k] <= NW'(nm3[k][0]) - NW'(nm3[k][1]);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) c4_r <= '0;
    else if (en) c4_r <= '{valid: c3_r.valid, sep: c3_r.sep | edge_sep};
  end

  // stage 5: normal dot and radius as split partial products
  logic signed [NH+VW-1:0] dh5 [3];
  logic signed [NL+VW:0] dl5 [3];
  logic signed [HW+SH:0] rh5;
  logic signed [HW+SL:0] rl5;
  logic [NSW-1:0] nabs;
  always_comb begin
    nabs = '0;
    for (int k = 0; k < 3; k++)
      nabs = nabs + NSW'(n4_r[k] < 0 ? -NSW'(n4_r[k]) : NSW'(n4_r[k]));
  end
  for (genvar k = 0; k < 3; k++) begin : g_dot
    tbo_mul #(.AW(NH), .BW(VW)) u_dh (.clk(clk), .en(en),
      .a($signed(n4_r[k][NW-1:NL])), .b(v4_r[k]), .p_r(dh5[k]));
    tbo_mul #(.AW(NL + 1), .BW(VW)) u_dl (.clk(clk), .en(en),
      .a($signed({1'b0, n4_r[k][NL-1:0]})), .b(v4_r[k]), .p_r(dl5[k]));
  end
  tbo_mul #(.AW(HW), .BW(SH + 1)) u_rh (.clk(clk), .en(en),
    .a(h), .b($signed({1'b0, nabs[NSW-1:SL]})), .p_r(rh5));
  tbo_mul #(.AW(HW), .BW(SL + 1)) u_rl (.clk(clk), .en(en),
    .a(h), .b($signed({1'b0, nabs[SL-1:0]})), .p_r(rl5));
  always_ff @(posedge clk) begin
    if (!rst_n) c5_r <= '0;
    else if (en) c5_r <= c4_r;
  end

  // stage 6: merge partial products
  logic signed [DW-1:0] d6_r [3];
  logic [DW-1:0] rn6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++)
        d6_r[k] <= (DW'(dh5[k]) <<< NL) + DW'(dl5[k]);
      rn6_r <= (DW'(rh5) <<< SL) + DW'(rl5);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) c6_r <= '0;
    else if (en) c6_r <= c5_r;
  end

  // stage 7: normal test
  logic signed [DW-1:0] dsum;
  logic [DW-1:0] dabs;
  logic ov_r;
  assign dsum = d6_r[0] + d6_r[1] + d6_r[2];
  assign dabs = dsum < 0 ? sx(-dsum) : sx(dsum);
  always_ff @(posedge clk) begin
    if (en) ov_r <= !(c6_r.sep || (dabs > rn6_r));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) c7_r <= '0;
    else if (en) c7_r <= c6_r;
  end

  assign out_valid = c7_r.valid;
  assign out_overlaps = ov_r;
endmodule

/* hw/rtl/tbo_checker.sv */
// Port-level checks for triangle_box_overlap_test, bound to the top level.
// Depends only on the top-level ports.
module tbo_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_overlaps
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_overlaps))
    else $error("result changed while stalled");
  a_stall_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("valid after reset");
  a_no_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |-> !in_stall)
    else $error("input stalled while output drains");
endmodule

bind triangle_box_overlap_test tbo_checker u_tbo_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_overlaps(out_overlaps));
